FILE: rtl/core/ffha_pkg.sv
// shared types, constants and codes of the first-fit heap allocator
package ffha_pkg;

    localparam int MAX_BLOCKS_DEF = 32;
    localparam int ADDR_BITS_DEF  = 20;

    localparam int          HDR_W     = 8;
    localparam logic [7:0]  HDR_RESET = 8'd40;

    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_OOM     = 3'd2,
        ST_NULL    = 3'd3,
        ST_IGNORED = 3'd4,
        ST_FULL    = 3'd5
    } status_e;

    // per-cycle command to the cell chain
    typedef struct packed {
        logic pop;
        logic push;
    } chain_ctl_t;

endpackage

FILE: rtl/core/ffha_cell.sv
// one table entry: holds, takes its upper neighbor, or loads a pushed entry
module ffha_cell
    import ffha_pkg::*;
#(
    parameter int AW = ADDR_BITS_DEF
)
(
    input  logic          clk,
    input  logic          shift,
    input  logic          load,
    input  logic [AW-1:0] ld_start,
    input  logic [AW-1:0] ld_bytes,
    input  logic          ld_free,
    input  logic [AW-1:0] nx_start,
    input  logic [AW-1:0] nx_bytes,
    input  logic          nx_free,
    output logic [AW-1:0] start,
    output logic [AW-1:0] bytes,
    output logic          is_free
);

    logic [AW-1:0] start_reg;
    logic [AW-1:0] bytes_reg;
    logic          free_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            start_reg <= ld_start;
            bytes_reg <= ld_bytes;
            free_reg  <= ld_free;
        end
        else if (shift)
        begin
            start_reg <= nx_start;
            bytes_reg <= nx_bytes;
            free_reg  <= nx_free;
        end
    end

    assign start   = start_reg;
    assign bytes   = bytes_reg;
    assign is_free = free_reg;

endmodule

FILE: rtl/core/ffha_chain.sv
// row of entry cells forming a shift queue: pop at cell 0, push at the fill level
module ffha_chain
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int AW         = ADDR_BITS_DEF,
    parameter int CW         = $clog2(MAX_BLOCKS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  chain_ctl_t    ctl,
    input  logic [AW-1:0] push_start,
    input  logic [AW-1:0] push_bytes,
    input  logic          push_free,
    output logic [AW-1:0] head_start,
    output logic [AW-1:0] head_bytes,
    output logic          head_free,
    output logic [CW-1:0] count
);

    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic [CW-1:0] pos;

    logic [AW-1:0] c_start [MAX_BLOCKS];
    logic [AW-1:0] c_bytes [MAX_BLOCKS];
    logic          c_free  [MAX_BLOCKS];
    logic [AW-1:0] n_start [MAX_BLOCKS];
    logic [AW-1:0] n_bytes [MAX_BLOCKS];
    logic          n_free  [MAX_BLOCKS];

    // a push lands just above what remains after this cycle's pop
    assign pos      = occ_reg - CW'(ctl.pop);
    assign occ_next = pos + CW'(ctl.push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_cell
        if (k < MAX_BLOCKS - 1)
        begin : g_mid
            assign n_start[k] = c_start[k+1];
            assign n_bytes[k] = c_bytes[k+1];
            assign n_free[k]  = c_free[k+1];
        end
        else
        begin : g_top
            assign n_start[k] = c_start[k];
            assign n_bytes[k] = c_bytes[k];
            assign n_free[k]  = c_free[k];
        end

        ffha_cell #(.AW(AW)) u_cell (
            .clk      (clk),
            .shift    (ctl.pop),
            .load     (ctl.push && (pos == CW'(k))),
            .ld_start (push_start),
            .ld_bytes (push_bytes),
            .ld_free  (push_free),
            .nx_start (n_start[k]),
            .nx_bytes (n_bytes[k]),
            .nx_free  (n_free[k]),
            .start    (c_start[k]),
            .bytes    (c_bytes[k]),
            .is_free  (c_free[k])
        );
    end

    assign head_start = c_start[0];
    assign head_bytes = c_bytes[0];
    assign head_free  = c_free[0];
    assign count      = occ_reg;

endmodule

FILE: rtl/core/ffha_ctrl.sv
// request sequencer: search pass, rewrite pass with split/merge, trim and result
module ffha_ctrl
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int AW         = ADDR_BITS_DEF,
    parameter int CW         = $clog2(MAX_BLOCKS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             op,
    input  logic [AW-1:0]    req_size,
    input  logic [AW-1:0]    ptr_in,
    input  logic [HDR_W-1:0] hdr,
    input  logic [AW-1:0]    limit,
    input  logic             out_ready,
    input  logic [AW-1:0]    head_start,
    input  logic [AW-1:0]    head_bytes,
    input  logic             head_free,
    input  logic [CW-1:0]    count,
    output chain_ctl_t       ctl,
    output logic [AW-1:0]    w_start,
    output logic [AW-1:0]    w_bytes,
    output logic             w_free,
    output logic             idle,
    output logic             done,
    output logic [AW-1:0]    res_ptr,
    output status_e          res_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EDIT,
        S_FLUSH,
        S_DONE
    } state_t;

    state_t        state_reg,    state_next;
    logic [CW-1:0] t_reg,        t_next;
    logic [CW-1:0] cnt_reg,      cnt_next;
    logic [CW-1:0] hit_reg,      hit_next;
    logic          found_reg,    found_next;
    logic          hit_free_reg, hit_free_next;
    logic          op_reg,       op_next;
    logic [AW:0]   size_reg,     size_next;
    logic [AW-1:0] ptr_reg,      ptr_next;
    logic [AW-1:0] p_start_reg,  p_start_next;
    logic [AW-1:0] p_bytes_reg,  p_bytes_next;
    logic          p_free_reg,   p_free_next;
    logic          p_valid_reg,  p_valid_next;
    logic [AW-1:0] res_ptr_reg,  res_ptr_next;
    status_e       res_st_reg,   res_st_next;
    logic [AW:0]   brk_reg,      brk_next;

    logic [AW:0]   req_rnd;
    logic          fit;
    logic          match;
    logic          split;
    logic [AW+2:0] grow_end;
    logic          e_free;

    // request rounded up to a multiple of four, one bit wider for the carry
    assign req_rnd = {1'b0, req_size} + (AW+1)'(3);

    assign fit   = head_free && ({1'b0, head_bytes} >= size_reg);
    assign match = (op_reg == OP_ALLOC) ? fit
                 : (({1'b0, head_start} + (AW+1)'(hdr)) == {1'b0, ptr_reg});
    assign split = ({2'b00, head_bytes} > ({1'b0, size_reg} + (AW+2)'(hdr)))
                && (cnt_reg < CW'(MAX_BLOCKS));
    assign grow_end = (AW+3)'(brk_reg) + (AW+3)'(hdr) + (AW+3)'(size_reg);
    assign e_free   = head_free || (t_reg == hit_reg);

    always_comb
    begin
        state_next    = state_reg;
        t_next        = t_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        hit_free_next = hit_free_reg;
        op_next       = op_reg;
        size_next     = size_reg;
        ptr_next      = ptr_reg;
        p_start_next  = p_start_reg;
        p_bytes_next  = p_bytes_reg;
        p_free_next   = p_free_reg;
        p_valid_next  = p_valid_reg;
        res_ptr_next  = res_ptr_reg;
        res_st_next   = res_st_reg;
        brk_next      = brk_reg;
        ctl.pop       = 1'b0;
        ctl.push      = 1'b0;
        w_start       = head_start;
        w_bytes       = head_bytes;
        w_free        = head_free;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = op;
                    size_next    = {req_rnd[AW:2], 2'b00};
                    ptr_next     = ptr_in;
                    cnt_next     = count;
                    t_next       = '0;
                    found_next   = 1'b0;
                    p_valid_next = 1'b0;
                    res_ptr_next = '0;
                    if (op == OP_ALLOC && req_size == '0)
                    begin
                        res_st_next = ST_ZERO;
                        state_next  = S_DONE;
                    end
                    else if (op == OP_FREE && ptr_in == '0)
                    begin
                        res_st_next = ST_NULL;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (t_reg != cnt_reg)
                begin
                    // rotate every entry once, noting the first hit
                    ctl.pop  = 1'b1;
                    ctl.push = 1'b1;
                    if (!found_reg && match)
                    begin
                        found_next    = 1'b1;
                        hit_next      = t_reg;
                        hit_free_next = head_free;
                    end
                    t_next = t_reg + CW'(1);
                end
                else
                begin
                    t_next = '0;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (found_reg)
                            state_next = S_EDIT;
                        else if (cnt_reg >= CW'(MAX_BLOCKS))
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (grow_end > (AW+3)'(limit))
                        begin
                            res_st_next = ST_OOM;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            // grow at the break
                            ctl.push     = 1'b1;
                            w_start      = brk_reg[AW-1:0];
                            w_bytes      = size_reg[AW-1:0];
                            w_free       = 1'b0;
                            res_ptr_next = brk_reg[AW-1:0] + AW'(hdr);
                            brk_next     = grow_end[AW:0];
                            res_st_next  = ST_OK;
                            state_next   = S_DONE;
                        end
                    end
                    else if (!found_reg || hit_free_reg)
                    begin
                        res_st_next = ST_IGNORED;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_EDIT;
                end
            end

            S_EDIT:
            begin
                if (t_reg != cnt_reg)
                begin
                    ctl.pop = 1'b1;
                    t_next  = t_reg + CW'(1);
                    if (op_reg == OP_ALLOC)
                    begin
                        if (p_valid_reg)
                        begin
                            // one-entry delay after a split
                            ctl.push     = 1'b1;
                            w_start      = p_start_reg;
                            w_bytes      = p_bytes_reg;
                            w_free       = p_free_reg;
                            p_start_next = head_start;
                            p_bytes_next = head_bytes;
                            p_free_next  = head_free;
                        end
                        else if (t_reg == hit_reg)
                        begin
                            ctl.push     = 1'b1;
                            w_free       = 1'b0;
                            res_ptr_next = head_start + AW'(hdr);
                            res_st_next  = ST_OK;
                            if (split)
                            begin
                                w_bytes      = size_reg[AW-1:0];
                                p_start_next = head_start + AW'(hdr) + size_reg[AW-1:0];
                                p_bytes_next = head_bytes - size_reg[AW-1:0] - AW'(hdr);
                                p_free_next  = 1'b1;
                                p_valid_next = 1'b1;
                            end
                        end
                        else
                            ctl.push = 1'b1;
                    end
                    else
                    begin
                        if (p_valid_reg && p_free_reg && e_free)
                            // coalesce into the running free block
                            p_bytes_next = p_bytes_reg + head_bytes + AW'(hdr);
                        else
                        begin
                            ctl.push     = p_valid_reg;
                            w_start      = p_start_reg;
                            w_bytes      = p_bytes_reg;
                            w_free       = p_free_reg;
                            p_start_next = head_start;
                            p_bytes_next = head_bytes;
                            p_free_next  = e_free;
                            p_valid_next = 1'b1;
                        end
                    end
                end
                else
                    state_next = S_FLUSH;
            end

            S_FLUSH:
            begin
                p_valid_next = 1'b0;
                res_st_next  = ST_OK;
                state_next   = S_DONE;
                w_start      = p_start_reg;
                w_bytes      = p_bytes_reg;
                w_free       = p_free_reg;
                if (p_valid_reg)
                begin
                    // a free tail goes back to the break
                    if (op_reg == OP_FREE && p_free_reg)
                        brk_next = {1'b0, p_start_reg};
                    else
                        ctl.push = 1'b1;
                end
            end

            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            t_reg       <= '0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            p_valid_reg <= 1'b0;
            brk_reg     <= '0;
            res_ptr_reg <= '0;
            res_st_reg  <= ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            t_reg       <= t_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            p_valid_reg <= p_valid_next;
            brk_reg     <= brk_next;
            res_ptr_reg <= res_ptr_next;
            res_st_reg  <= res_st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        hit_free_reg <= hit_free_next;
        op_reg       <= op_next;
        size_reg     <= size_next;
        ptr_reg      <= ptr_next;
        p_start_reg  <= p_start_next;
        p_bytes_reg  <= p_bytes_next;
        p_free_reg   <= p_free_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign res_ptr    = res_ptr_reg;
    assign res_status = res_st_reg;

endmodule

FILE: rtl/core/first_fit_heap_allocator.sv
// top level of the first-fit heap allocator with coalescing
//
// The allocator keeps an address-ordered table of up to MAX_BLOCKS heap
// blocks (start, size, free flag) in a row of cells that work as a shift
// queue, plus the heap break. Each beat on the slave side is one request:
// allocate (rounded to 4 bytes, first fit, split when large enough, else
// grow at the break) or free (mark free, coalesce neighbors, give a free tail
// back to the break). Each request yields exactly one result beat. A request
// that edits a block in place makes one full rotation of the cell queue to
// search and one more to rewrite it, besides setup, tail handling and
// hand-off. Requests that end after the search (growth at the break, out of
// memory, table full, ignored free) skip the rewrite; zero-size and null
// requests finish without a search. Requests are handled one at a time, but
// the result sits in an output register so the next request is taken while
// it waits.
// The user writes header_bytes and heap_limit on the cfg port only while idle; the block does not enforce it.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*ADDR_BITS+7)/8)*8-1:0]      s_tdata,  // req_size, ptr_in
    input  logic                                  s_tuser,  // op
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((ADDR_BITS+STATUS_W+7)/8)*8-1:0] m_tdata, // ptr_out, status
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [ADDR_BITS-1:0]                  cfg_data
);

    localparam int AW    = ADDR_BITS;
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int OUT_W = ((ADDR_BITS + STATUS_W + 7) / 8) * 8;

    // configuration registers
    logic [HDR_W-1:0] hdr_reg;
    logic [AW-1:0]    limit_reg;

    // result register
    logic             m_valid_reg;
    logic [AW-1:0]    out_ptr_reg;
    status_e          out_st_reg;

    chain_ctl_t       ctl;
    logic [AW-1:0]    w_start, w_bytes;
    logic             w_free;
    logic [AW-1:0]    head_start, head_bytes;
    logic             head_free;
    logic [CW-1:0]    count;
    logic             idle, done;
    logic [AW-1:0]    res_ptr;
    status_e          res_status;
    logic             s_accept;
    logic             out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg   <= HDR_RESET;
            limit_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEADER: hdr_reg   <= cfg_data[HDR_W-1:0];
                CFG_LIMIT:  limit_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // a new request is taken whenever the sequencer is free
    assign s_tready = idle;
    assign s_accept = s_tvalid && s_tready;

    // a finished result moves into the output register once it is empty or draining
    assign out_load = done && (!m_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ptr_reg <= res_ptr;
            out_st_reg  <= res_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({out_st_reg, out_ptr_reg});

    // block table held in the cell row
    ffha_chain #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW),
        .CW         (CW)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .push_start (w_start),
        .push_bytes (w_bytes),
        .push_free  (w_free),
        .head_start (head_start),
        .head_bytes (head_bytes),
        .head_free  (head_free),
        .count      (count)
    );

    // search / rewrite sequencer
    ffha_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s_accept),
        .op         (s_tuser),
        .req_size   (s_tdata[AW-1:0]),
        .ptr_in     (s_tdata[2*AW-1:AW]),
        .hdr        (hdr_reg),
        .limit      (limit_reg),
        .out_ready  (!m_valid_reg || m_tready),
        .head_start (head_start),
        .head_bytes (head_bytes),
        .head_free  (head_free),
        .count      (count),
        .ctl        (ctl),
        .w_start    (w_start),
        .w_bytes    (w_bytes),
        .w_free     (w_free),
        .idle       (idle),
        .done       (done),
        .res_ptr    (res_ptr),
        .res_status (res_status)
    );

    // table never holds more entries than cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(MAX_BLOCKS))
        else $error("block count above table size");

    // the sequencer never offers a result while taking a request
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(idle && done))
        else $error("sequencer idle and done at once");

    // without a request the table's entry count stays unchanged
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (idle && !s_tvalid) |=> $stable(count))
        else $error("table changed while idle");

endmodule
